[rtl/pea_pkg.sv]
// pea_pkg: shared types and constants for the photon event image accumulator.
// Holds the channel payload structs, the decoded pixel struct and register codes.
// No dependencies.
package pea_pkg;

    // Default geometry and counter width
    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 512;
    localparam int COUNT_BITS_DEF   = 16;

    // Fixed field widths of the event word and the ports
    localparam int COORD_W = 12;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_BIN_SHIFT = 2'd0;
    localparam logic [IDX_W-1:0] REG_X_OFFSET  = 2'd1;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET  = 2'd2;

    // Register reset values
    localparam logic [1:0]         BIN_SHIFT_RST = 2'd1;
    localparam logic [COORD_W-1:0] X_OFFSET_RST  = 12'd1024;
    localparam logic [COORD_W-1:0] Y_OFFSET_RST  = 12'd240;

    // Command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Input transaction
    typedef struct packed {
        logic        cmd;
        logic [31:0] event_word;
        logic [9:0]  read_col;
        logic [8:0]  read_row;
    } pea_in_t;

    // Result transaction
    typedef struct packed {
        logic        in_image;
        logic [9:0]  pixel_col;
        logic [8:0]  pixel_row;
        logic [15:0] pixel_count;
        logic        saturated;
    } pea_out_t;

    // Decoded pixel request passed from the decode stage to the update stage
    typedef struct packed {
        logic               cmd;
        logic               in_image;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pea_coord_t;

endpackage

[rtl/pea_ram.sv]
// pea_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module pea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pea_coord.sv]
// pea_coord: decodes an input transaction into a pixel position and linear address.
// Depends on pea_pkg.
module pea_coord #(
    parameter int IMAGE_WIDTH  = pea_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = pea_pkg::IMAGE_HEIGHT_DEF,
    parameter int ADDR_W       = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT)
) (
    input  pea_pkg::pea_in_t                 in_data,
    input  logic [1:0]                       bin_shift,
    input  logic [pea_pkg::COORD_W-1:0]      x_offset,
    input  logic [pea_pkg::COORD_W-1:0]      y_offset,
    output pea_pkg::pea_coord_t              coord,
    output logic [ADDR_W-1:0]                addr
);

    localparam int CW = pea_pkg::COORD_W;

    logic [CW-1:0] rx_bin;
    logic [CW-1:0] ry_bin;
    logic [CW:0]   dx;
    logic [CW:0]   dy;
    logic          ev_in;
    logic          rd_in;
    logic [CW-1:0] col_sel;
    logic [CW-1:0] row_sel;
    logic [2*CW:0] lin;

    // Binning and offset; the top bit of dx/dy is the borrow (negative)
    always_comb
    begin
        rx_bin = in_data.event_word[2*CW-1:CW] >> bin_shift;
        ry_bin = in_data.event_word[CW-1:0] >> bin_shift;
        dx     = {1'b0, rx_bin} - {1'b0, x_offset};
        dy     = {1'b0, ry_bin} - {1'b0, y_offset};
        ev_in  = !dx[CW] && (dx[CW-1:0] != '0) && ({1'b0, dx[CW-1:0]} < (CW+1)'(IMAGE_WIDTH))
              && !dy[CW] && (dy[CW-1:0] != '0) && ({1'b0, dy[CW-1:0]} < (CW+1)'(IMAGE_HEIGHT));
        rd_in  = ((CW+1)'(in_data.read_col) < (CW+1)'(IMAGE_WIDTH))
              && ((CW+1)'(in_data.read_row) < (CW+1)'(IMAGE_HEIGHT));
    end

    // Select the pixel for the command
    always_comb
    begin
        unique case (in_data.cmd)
            pea_pkg::CMD_ACCUM:
            begin
                col_sel = dx[CW-1:0];
                row_sel = dy[CW-1:0];
                coord.in_image = ev_in;
            end
            pea_pkg::CMD_READ:
            begin
                col_sel = CW'(in_data.read_col);
                row_sel = CW'(in_data.read_row);
                coord.in_image = rd_in;
            end
        endcase
        coord.cmd = in_data.cmd;
        coord.col = col_sel;
        coord.row = row_sel;
    end

    // Linear address: row * width + col
    assign lin  = (2*CW+1)'(row_sel) * (2*CW+1)'(IMAGE_WIDTH) + (2*CW+1)'(col_sel);
    assign addr = lin[ADDR_W-1:0];

endmodule

[rtl/pea_rmw.sv]
// pea_rmw: update stage; takes the read count, forwards the last write,
// saturating increment, write back and result build. Depends on pea_pkg.
module pea_rmw #(
    parameter int COUNT_BITS = pea_pkg::COUNT_BITS_DEF,
    parameter int ADDR_W     = 19
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  pea_pkg::pea_coord_t   coord_in,
    input  logic [ADDR_W-1:0]     addr_in,
    input  logic [COUNT_BITS-1:0] rdata,
    input  logic                  advance,
    output logic                  busy,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [COUNT_BITS-1:0] wr_data,
    output pea_pkg::pea_out_t     result
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    pea_pkg::pea_coord_t   s1_coord_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;

    logic                  lw_valid_reg;
    logic [ADDR_W-1:0]     lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;

    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] new_count;
    logic                  is_max;
    logic [31:0]           count_ext;

    // Stage valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_coord_reg <= coord_in;
            s1_addr_reg  <= addr_in;
        end
    end

    // Forward the write made at the same edge as this entry's read
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == s1_addr_reg))
        begin
            cur_count = lw_data_reg;
        end
        else
        begin
            cur_count = rdata;
        end
        is_max = (cur_count == '1);
        if ((s1_coord_reg.cmd == pea_pkg::CMD_ACCUM) && !is_max)
        begin
            new_count = cur_count + 1'b1;
        end
        else
        begin
            new_count = cur_count;
        end
    end

    // Write back accumulated pixels as the result leaves
    assign busy    = s1_valid_reg;
    assign wr_en   = s1_valid_reg && advance && s1_coord_reg.in_image
                  && (s1_coord_reg.cmd == pea_pkg::CMD_ACCUM);
    assign wr_addr = s1_addr_reg;
    assign wr_data = new_count;

    // Last-write record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= new_count;
        end
    end

    // Result; all fields zero outside the image
    always_comb
    begin
        count_ext = 32'(new_count);
        result    = '0;
        if (s1_coord_reg.in_image)
        begin
            result.in_image    = 1'b1;
            result.pixel_col   = s1_coord_reg.col[9:0];
            result.pixel_row   = s1_coord_reg.row[8:0];
            result.pixel_count = count_ext[15:0];
            result.saturated   = (new_count == '1);
        end
    end

endmodule

[rtl/photon_event_image_accumulator.sv]
// Photon event image accumulator: top level with registers, clear sequencer,
// pixel count RAM and output register. Depends on pea_pkg, pea_ram, pea_coord, pea_rmw.
// A transaction moves from the update stage register into the output register.
// Throughput: one transaction per cycle unless out_stall holds the output register;
// a read-modify-write of the count RAM per cycle, with the previous write forwarded
// to the next read. Reset: registers take their defaults, then a clearing pass zeroes
// the RAM one entry a cycle (all 327680 entries by default) with in_stall held high.
module photon_event_image_accumulator #(
    parameter int IMAGE_WIDTH  = pea_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = pea_pkg::IMAGE_HEIGHT_DEF,
    parameter int COUNT_BITS   = pea_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pea_pkg::pea_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output pea_pkg::pea_out_t          out_data,
    input  logic                       cfg_we,
    input  logic [pea_pkg::IDX_W-1:0]  cfg_index,
    input  logic [pea_pkg::CFG_W-1:0]  cfg_data
);

    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = pea_pkg::COORD_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [ADDR_W-1:0]     clear_cnt_reg;
    logic [ADDR_W-1:0]     clear_cnt_next;

    logic [1:0]            bin_shift_reg;
    logic [CW-1:0]         x_offset_reg;
    logic [CW-1:0]         y_offset_reg;

    pea_pkg::pea_coord_t   coord;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  accept;
    logic                  advance;
    logic                  s1_busy;
    logic                  upd_we;
    logic [ADDR_W-1:0]     upd_addr;
    logic [COUNT_BITS-1:0] upd_data;
    logic [COUNT_BITS-1:0] ram_rdata;
    pea_pkg::pea_out_t     result;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    pea_pkg::pea_out_t     out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_shift_reg <= pea_pkg::BIN_SHIFT_RST;
            x_offset_reg  <= pea_pkg::X_OFFSET_RST;
            y_offset_reg  <= pea_pkg::Y_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pea_pkg::REG_BIN_SHIFT: bin_shift_reg <= cfg_data[1:0];
                pea_pkg::REG_X_OFFSET:  x_offset_reg  <= cfg_data[CW-1:0];
                pea_pkg::REG_Y_OFFSET:  y_offset_reg  <= cfg_data[CW-1:0];
                default:                ;
            endcase
        end
    end

    // Clearing pass after reset
    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // Handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_RUN) && (!s1_busy || advance));
    assign accept   = in_valid && !in_stall;

    // Decode
    pea_coord #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_coord (
        .in_data   (in_data),
        .bin_shift (bin_shift_reg),
        .x_offset  (x_offset_reg),
        .y_offset  (y_offset_reg),
        .coord     (coord),
        .addr      (rd_addr)
    );

    // Update stage
    pea_rmw #(
        .COUNT_BITS (COUNT_BITS),
        .ADDR_W     (ADDR_W)
    ) u_rmw (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (accept),
        .coord_in (coord),
        .addr_in  (rd_addr),
        .rdata    (ram_rdata),
        .advance  (advance),
        .busy     (s1_busy),
        .wr_en    (upd_we),
        .wr_addr  (upd_addr),
        .wr_data  (upd_data),
        .result   (result)
    );

    // Write port shared by the clearing pass and the update stage
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = upd_we;
            ram_waddr = upd_addr;
            ram_wdata = upd_data;
        end
    end

    pea_ram #(
        .WIDTH  (COUNT_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && coord.in_image),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_busy)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_busy)
        else $error("update stage active during clearing pass");

    a_write_lands_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_we |=> out_valid_reg && out_data_reg.in_image)
        else $error("count written without a result in the output register");

    a_outside_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.in_image) |->
        (out_data_reg.pixel_count == 16'd0) && !out_data_reg.saturated)
        else $error("result outside the image carries data");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_busy && out_valid_reg && out_stall) |-> !accept)
        else $error("transaction accepted with the pipeline blocked");

endmodule

[dv/tb_photon_event_image_accumulator.sv]
// Self-checking testbench for photon_event_image_accumulator: directed table, a
// back-to-back burst on one pixel and random phases under several register settings.
// Depends on pea_pkg and the RTL of photon_event_image_accumulator.
module tb_photon_event_image_accumulator;

    localparam int IMG_W          = pea_pkg::IMAGE_WIDTH_DEF;
    localparam int IMG_H          = pea_pkg::IMAGE_HEIGHT_DEF;
    localparam int COUNT_MAX      = (1 << pea_pkg::COUNT_BITS_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int HOT_EVENTS     = 20;
    localparam int IW             = pea_pkg::IDX_W;
    localparam int CFW            = pea_pkg::CFG_W;
    localparam logic [IW-1:0] REG_SPARE = 2'd3;   // unmapped index, must be ignored

    // Short names for the command codes used in the table
    localparam logic CMD_AC = pea_pkg::CMD_ACCUM;
    localparam logic CMD_RD = pea_pkg::CMD_READ;

    // One row of the directed table; typed is used only when has_typed is set
    typedef struct packed {
        pea_pkg::pea_in_t  item;
        logic              has_typed;
        pea_pkg::pea_out_t typed;
    } dir_row_t;

    localparam pea_pkg::pea_out_t NO_HIT   = '0;
    localparam int                DIR_ROWS = 19;

    // Directed rows under the reset register values (shift 1, x 1024, y 240)
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // reads right after the clear, corners and out-of-range columns
        '{'{CMD_RD, 32'h0000_0000, 10'd0, 9'd0}, 1'b1, '{1'b1, 10'd0, 9'd0, 16'd0, 1'b0}},
        '{'{CMD_RD, 32'h0000_0000, 10'd639, 9'd511}, 1'b1,
          '{1'b1, 10'd639, 9'd511, 16'd0, 1'b0}},
        '{'{CMD_RD, 32'h0000_0000, 10'd640, 9'd0}, 1'b1, NO_HIT},
        '{'{CMD_RD, 32'hFFFF_FFFF, 10'd1023, 9'd511}, 1'b1, NO_HIT},
        // events that miss: all zero, all ones, x zero, y zero
        '{'{CMD_AC, 32'h0000_0000, 10'd1023, 9'd511}, 1'b1, NO_HIT},
        '{'{CMD_AC, 32'hFFFF_FFFF, 10'd0, 9'd0}, 1'b1, NO_HIT},
        '{'{CMD_AC, {8'h00, 12'd2048, 12'd482}, 10'd0, 9'd0}, 1'b1, NO_HIT},
        '{'{CMD_AC, {8'h00, 12'd2050, 12'd480}, 10'd0, 9'd0}, 1'b1, NO_HIT},
        // first pixel inside, twice back to back, then the far corner
        '{'{CMD_AC, {8'hA5, 12'd2050, 12'd482}, 10'd0, 9'd0}, 1'b1,
          '{1'b1, 10'd1, 9'd1, 16'd1, 1'b0}},
        '{'{CMD_AC, {8'h5A, 12'd2051, 12'd483}, 10'd0, 9'd0}, 1'b1,
          '{1'b1, 10'd1, 9'd1, 16'd2, 1'b0}},
        '{'{CMD_AC, {8'hFF, 12'd3327, 12'd1503}, 10'd0, 9'd0}, 1'b1,
          '{1'b1, 10'd639, 9'd511, 16'd1, 1'b0}},
        // just past the right and bottom edges, and x one below zero
        '{'{CMD_AC, {8'h00, 12'd3328, 12'd1502}, 10'd0, 9'd0}, 1'b1, NO_HIT},
        '{'{CMD_AC, {8'h00, 12'd3326, 12'd1504}, 10'd0, 9'd0}, 1'b1, NO_HIT},
        '{'{CMD_AC, {8'h00, 12'd2047, 12'd482}, 10'd0, 9'd0}, 1'b1, NO_HIT},
        // read back what was counted
        '{'{CMD_RD, 32'hFFFF_FFFF, 10'd1, 9'd1}, 1'b1, '{1'b1, 10'd1, 9'd1, 16'd2, 1'b0}},
        '{'{CMD_RD, 32'h0000_0000, 10'd639, 9'd511}, 1'b1,
          '{1'b1, 10'd639, 9'd511, 16'd1, 1'b0}},
        // update immediately followed by a read of the same pixel
        '{'{CMD_AC, {8'hFF, 12'd2050, 12'd482}, 10'd1023, 9'd511}, 1'b0, NO_HIT},
        '{'{CMD_RD, 32'h1234_5678, 10'd1, 9'd1}, 1'b0, NO_HIT},
        '{'{CMD_RD, 32'h0000_0000, 10'd0, 9'd511}, 1'b1, '{1'b1, 10'd0, 9'd511, 16'd0, 1'b0}}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    pea_pkg::pea_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    pea_pkg::pea_out_t out_data;
    logic              cfg_we    = 1'b0;
    logic [IW-1:0]     cfg_index = '0;
    logic [CFW-1:0]    cfg_data  = '0;

    // Mirror of the image and of the registers
    bit   [pea_pkg::COUNT_BITS_DEF-1:0] pix_count [IMG_W*IMG_H];
    logic [1:0]                         bin_shift_m = pea_pkg::BIN_SHIFT_RST;
    logic [pea_pkg::COORD_W-1:0]        x_off_m     = pea_pkg::X_OFFSET_RST;
    logic [pea_pkg::COORD_W-1:0]        y_off_m     = pea_pkg::Y_OFFSET_RST;

    pea_pkg::pea_out_t pix_expect [$];
    bit                typed_valid  = 1'b0;
    pea_pkg::pea_out_t typed_result = '0;

    int          mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          burst_left   = 0;
    int          stall_left   = 0;

    photon_event_image_accumulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Expected result of one transaction; updates the image mirror on a hit
    function automatic pea_pkg::pea_out_t predict_pixel(pea_pkg::pea_in_t t);
        pea_pkg::pea_out_t r;
        int       rx;
        int       ry;
        int       dx;
        int       dy;
        int       idx;
        r = '0;
        if (t.cmd == pea_pkg::CMD_ACCUM)
        begin
            rx = t.event_word[23:12];
            ry = t.event_word[11:0];
            dx = (rx >> bin_shift_m) - int'(x_off_m);
            dy = (ry >> bin_shift_m) - int'(y_off_m);
            if (dx > 0 && dx < IMG_W && dy > 0 && dy < IMG_H)
            begin
                idx = dx + dy * IMG_W;
                if (pix_count[idx] != COUNT_MAX)
                    pix_count[idx] = pix_count[idx] + 1'b1;
                r.in_image    = 1'b1;
                r.pixel_col   = dx[9:0];
                r.pixel_row   = dy[8:0];
                r.pixel_count = pix_count[idx];
            end
        end
        else if (t.read_col < IMG_W && t.read_row < IMG_H)
        begin
            idx           = int'(t.read_col) + int'(t.read_row) * IMG_W;
            r.in_image    = 1'b1;
            r.pixel_col   = t.read_col;
            r.pixel_row   = t.read_row;
            r.pixel_count = pix_count[idx];
        end
        r.saturated = r.in_image && (r.pixel_count == COUNT_MAX);
        return r;
    endfunction

    // Event word that lands on pixel (dx, dy) under the current registers, if one exists
    function automatic logic [31:0] event_for_pixel(int dx, int dy);
        int span;
        int rx;
        int ry;
        span = 1 << bin_shift_m;
        rx   = (dx + int'(x_off_m)) * span + $urandom_range(0, span - 1);
        ry   = (dy + int'(y_off_m)) * span + $urandom_range(0, span - 1);
        if (rx > 4095 || ry > 4095)
            return $urandom;
        return {8'($urandom), 12'(rx), 12'(ry)};
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endtask

    // Input side: predict every accepted transaction
    always @(posedge clk)
    begin
        pea_pkg::pea_out_t predicted;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted = predict_pixel(in_data);
            pix_expect.push_back(typed_valid ? typed_result : predicted);
        end
    end

    // Output side: compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        pea_pkg::pea_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pix_expect.size() == 0)
            begin
                mismatches++;
                $error("result with nothing expected: 0x%0h", out_data);
            end
            else
            begin
                want = pix_expect.pop_front();
                check_field("in_image", want.in_image, out_data.in_image);
                check_field("pixel_col", want.pixel_col, out_data.pixel_col);
                check_field("pixel_row", want.pixel_row, out_data.pixel_row);
                check_field("pixel_count", want.pixel_count, out_data.pixel_count);
                check_field("saturated", want.saturated, out_data.saturated);
            end
        end
    end

    // Receiver stall pattern: runs of stall and no stall of random length
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 6);
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(1, 8);
            end
        end
        else
            stall_left--;
    end

    // Watchdog on cycles where neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one transaction and hold it until accepted; then maybe open a gap
    task automatic send_item(input pea_pkg::pea_in_t item, input bit has_typed,
                             input pea_pkg::pea_out_t typed);
        in_data      <= item;
        in_valid     <= 1'b1;
        typed_valid  = has_typed;
        typed_result = typed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    // Stop sending and wait until every expected result is back
    task automatic settle();
        in_valid    <= 1'b0;
        typed_valid = 1'b0;
        while (pix_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all registers; optionally poke the unmapped index as well
    task automatic load_config(input logic [CFW-1:0] shift_v, input logic [CFW-1:0] x_v,
                               input logic [CFW-1:0] y_v, input bit poke_spare);
        logic [IW-1:0]  idx_list [4];
        logic [CFW-1:0] val_list [4];
        idx_list = '{pea_pkg::REG_BIN_SHIFT, pea_pkg::REG_X_OFFSET, pea_pkg::REG_Y_OFFSET,
                     REG_SPARE};
        val_list = '{shift_v, x_v, y_v, CFW'($urandom)};
        for (int k = 0; k < (poke_spare ? 4 : 3); k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= val_list[k];
            @(posedge clk);
            case (idx_list[k])
                pea_pkg::REG_BIN_SHIFT: bin_shift_m = val_list[k][1:0];
                pea_pkg::REG_X_OFFSET:  x_off_m     = val_list[k];
                pea_pkg::REG_Y_OFFSET:  y_off_m     = val_list[k];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly events that land in the image, often on a small hot patch, plus reads and noise
    task automatic run_events(input int n_items);
        pea_pkg::pea_in_t item;
        int               pick;
        for (int n = 0; n < n_items; n++)
        begin
            item.cmd        = pea_pkg::CMD_ACCUM;
            item.event_word = $urandom;
            item.read_col   = $urandom_range(0, 1023);
            item.read_row   = $urandom_range(0, 511);
            pick            = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 1))
                    item.event_word = event_for_pixel($urandom_range(1, 6), $urandom_range(1, 6));
                else
                    item.event_word = event_for_pixel($urandom_range(1, IMG_W - 1),
                                                      $urandom_range(1, IMG_H - 1));
            end
            else if (pick < 85)
            begin
                item.cmd = pea_pkg::CMD_READ;
                if ($urandom_range(0, 1))
                begin
                    item.read_col = $urandom_range(0, 6);
                    item.read_row = $urandom_range(0, 6);
                end
            end
            send_item(item, 1'b0, NO_HIT);
        end
    endtask

    initial
    begin
        pea_pkg::pea_in_t item;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table under reset values; first transaction waits out the clear
        gap_pct   = 30;
        stall_pct = 30;
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].item, DIRECTED[r].has_typed, DIRECTED[r].typed);

        // Hammer one pixel back to back, no idling, then read it back
        gap_pct   = 0;
        stall_pct = 0;
        for (int k = 0; k < HOT_EVENTS; k++)
        begin
            item.cmd        = pea_pkg::CMD_ACCUM;
            item.event_word = event_for_pixel(2, 2);
            item.read_col   = $urandom_range(0, 1023);
            item.read_row   = $urandom_range(0, 511);
            send_item(item, 1'b0, NO_HIT);
        end
        send_item('{CMD_RD, 32'h0000_0000, 10'd2, 9'd2}, 1'b0, NO_HIT);
        settle();

        // No binning, no offsets
        load_config(12'd0, 12'd0, 12'd0, 1'b0);
        gap_pct   = 40;
        stall_pct = 40;
        run_events(200);
        settle();

        // Widest shift given as an oversized value, largest offsets: nothing lands
        load_config(12'hFFF, 12'd4095, 12'd4095, 1'b1);
        gap_pct   = 20;
        stall_pct = 60;
        run_events(60);
        settle();

        // Shift 2 with random moderate offsets
        load_config(12'd2, CFW'($urandom_range(0, 384)), CFW'($urandom_range(0, 384)), 1'b0);
        gap_pct   = 50;
        stall_pct = 20;
        run_events(200);
        settle();

        // Offsets that map the top of the raw range onto the image, full rate
        load_config(12'd0, 12'd3456, 12'd3584, 1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        run_events(140);
        settle();

        // Back to the reset values; hot patch includes the hammered pixel
        load_config(12'd1, 12'd1024, 12'd240, 1'b1);
        gap_pct   = 30;
        stall_pct = 30;
        run_events(60);
        settle();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/pea_pkg.sv
rtl/pea_ram.sv
rtl/pea_coord.sv
rtl/pea_rmw.sv
rtl/photon_event_image_accumulator.sv
dv/tb_photon_event_image_accumulator.sv
